@@ rtl/dstc_pkg.sv @@
// Shared types and constants for the disk sector to CHS command unit.
package dstc_pkg;

    // Default width of the relative sector input.
    localparam int SECTOR_WIDTH_DEF = 64;

    // Width of the cylinder-head-sector dividend and of the block address.
    localparam int CHS_W   = 32;
    localparam int BLOCK_W = 64;

    // Geometry register widths, which are also the divisor widths.
    localparam int SPT_W  = 6;
    localparam int HEAD_W = 9;

    // Configuration port widths.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Request status codes.
    typedef enum logic [1:0] {
        ST_LBA   = 2'd0,
        ST_CHS   = 2'd1,
        ST_NOMAP = 2'd2,
        ST_BIG   = 2'd3
    } status_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DISK_MAPPED = 3'd0,
        CFG_USE_LBA     = 3'd1,
        CFG_DRIVE       = 3'd2,
        CFG_START       = 3'd3,
        CFG_SPT         = 3'd4,
        CFG_HEADS       = 3'd5
    } cfg_index_t;

    // Command code that carries no buffer.
    localparam logic [1:0] FUNC_VERIFY = 2'd2;

    // Fields that travel alongside the division through every cell.
    typedef struct packed {
        status_t           status;
        logic [1:0]        command;
        logic [7:0]        count;
        logic [31:0]       buffer;
        logic [SPT_W-1:0]  sect;
    } dstc_side_t;

endpackage

@@ rtl/dstc_cell.sv @@
// One restoring-division cell: retires one quotient bit per beat.
module dstc_cell #(
    parameter int DIV_W = dstc_pkg::SPT_W
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [DIV_W-1:0]           divisor,
    input  logic                       in_valid,
    input  logic [DIV_W-1:0]           in_rem,
    input  logic [dstc_pkg::CHS_W-1:0] in_word,
    input  dstc_pkg::dstc_side_t       in_side,
    output logic                       out_valid,
    output logic [DIV_W-1:0]           out_rem,
    output logic [dstc_pkg::CHS_W-1:0] out_word,
    output dstc_pkg::dstc_side_t       out_side
);
    import dstc_pkg::*;

    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic             fits;
    logic [DIV_W-1:0] rem_next;
    logic [CHS_W-1:0] word_next;

    logic             valid_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [CHS_W-1:0] word_reg;
    dstc_side_t       side_reg;

    // Bring down the next dividend bit and try the subtraction. The word
    // shifts the dividend out at the top and the quotient in at the bottom.
    always_comb
    begin
        trial     = {in_rem, in_word[CHS_W-1]};
        diff      = trial - {1'b0, divisor};
        fits      = (trial >= {1'b0, divisor});
        rem_next  = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        word_next = {in_word[CHS_W-2:0], fits};
    end

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        word_reg <= word_next;
        side_reg <= in_side;
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_word  = word_reg;
    assign out_side  = side_reg;

endmodule

@@ rtl/dstc_chain.sv @@
// A row of division cells giving a full quotient and remainder.
module dstc_chain #(
    parameter int DIV_W = dstc_pkg::SPT_W
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [DIV_W-1:0]           divisor,
    input  logic                       in_valid,
    input  logic [dstc_pkg::CHS_W-1:0] in_dividend,
    input  dstc_pkg::dstc_side_t       in_side,
    output logic                       out_valid,
    output logic [DIV_W-1:0]           out_rem,
    output logic [dstc_pkg::CHS_W-1:0] out_quot,
    output dstc_pkg::dstc_side_t       out_side
);
    import dstc_pkg::*;

    logic [CHS_W:0]   valid_tap;
    logic [DIV_W-1:0] rem_tap  [CHS_W+1];
    logic [CHS_W-1:0] word_tap [CHS_W+1];
    dstc_side_t       side_tap [CHS_W+1];

    // The first cell starts from a zero remainder.
    assign valid_tap[0] = in_valid;
    assign rem_tap[0]   = '0;
    assign word_tap[0]  = in_dividend;
    assign side_tap[0]  = in_side;

    // One cell per dividend bit, most significant first.
    for (genvar i = 0; i < CHS_W; i++)
    begin : g_cell
        dstc_cell #(
            .DIV_W (DIV_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .divisor   (divisor),
            .in_valid  (valid_tap[i]),
            .in_rem    (rem_tap[i]),
            .in_word   (word_tap[i]),
            .in_side   (side_tap[i]),
            .out_valid (valid_tap[i+1]),
            .out_rem   (rem_tap[i+1]),
            .out_word  (word_tap[i+1]),
            .out_side  (side_tap[i+1])
        );
    end

    assign out_valid = valid_tap[CHS_W];
    assign out_rem   = rem_tap[CHS_W];
    assign out_quot  = word_tap[CHS_W];
    assign out_side  = side_tap[CHS_W];

endmodule

@@ rtl/disk_sector_to_chs_command_unit.sv @@
// Top level: disk command to logical block or cylinder-head-sector request.
//
//  channel  | handshake          | beat contents
//  ---------+--------------------+-----------------------------------------------
//  command  | start, busy        | func, sector, sector_count, buffer_address
//  request  | done (strobe)      | status, command, block_address, cyl_sector_word,
//           |                    | head_drive_word, count_out, buffer_out
//  config   | cfg_we             | cfg_index, cfg_data
//
// One command is taken every cycle while busy is low. In logical block mode and
// while no disk is mapped the request follows in the cycle after the command.
// In cylinder-head-sector mode it passes through an entry stage, two rows of
// 32 one-bit division cells (sectors per track, then heads) and the output
// register. busy is high only in the first cycle after reset; there is no
// clearing pass. The receiver cannot stall, so no stage ever holds.
module disk_sector_to_chs_command_unit #(
    parameter int SECTOR_WIDTH = dstc_pkg::SECTOR_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      func,
    input  logic [SECTOR_WIDTH-1:0]         sector,
    input  logic [7:0]                      sector_count,
    input  logic [31:0]                     buffer_address,
    output logic                            done,
    output logic [1:0]                      status,
    output logic [1:0]                      command,
    output logic [dstc_pkg::BLOCK_W-1:0]    block_address,
    output logic [15:0]                     cyl_sector_word,
    output logic [15:0]                     head_drive_word,
    output logic [7:0]                      count_out,
    output logic [31:0]                     buffer_out,
    input  logic                            cfg_we,
    input  logic [dstc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dstc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import dstc_pkg::*;

    // Configuration registers.
    logic               disk_mapped_reg;
    logic               use_lba_reg;
    logic [7:0]         drive_number_reg;
    logic [BLOCK_W-1:0] start_sector_reg;
    logic [SPT_W-1:0]   spt_reg;
    logic [HEAD_W-1:0]  heads_reg;

    logic               busy_reg;

    // Input decode.
    logic               accept;
    logic               short_mode;
    logic               short_acc;
    logic [BLOCK_W-1:0] sec_ext;
    logic               too_large;
    logic [31:0]        buf_pass;
    logic [SPT_W-1:0]   spt_eff;
    logic [HEAD_W-1:0]  heads_eff;

    // Entry stage of the division path.
    logic               s0_valid_next;
    logic [CHS_W-1:0]   s0_rel_next;
    dstc_side_t         s0_side_next;
    logic               s0_valid_reg;
    logic [CHS_W-1:0]   s0_rel_reg;
    dstc_side_t         s0_side_reg;

    // Division rows.
    logic               c1_valid;
    logic [SPT_W-1:0]   c1_rem;
    logic [CHS_W-1:0]   c1_quot;
    dstc_side_t         c1_side;
    dstc_side_t         mid_side;
    logic               c2_valid;
    logic [HEAD_W-1:0]  c2_rem;
    logic [CHS_W-1:0]   c2_quot;
    dstc_side_t         c2_side;

    // Output stage.
    logic               done_next;
    status_t            status_next;
    logic [1:0]         command_next;
    logic [BLOCK_W-1:0] block_next;
    logic [15:0]        cs_word_next;
    logic [15:0]        hd_word_next;
    logic [7:0]         count_next;
    logic [31:0]        buffer_next;
    logic               done_reg;
    status_t            status_reg;
    logic [1:0]         command_reg;
    logic [BLOCK_W-1:0] block_reg;
    logic [15:0]        cs_word_reg;
    logic [15:0]        hd_word_reg;
    logic [7:0]         count_reg;
    logic [31:0]        buffer_reg;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disk_mapped_reg  <= 1'b0;
            use_lba_reg      <= 1'b0;
            drive_number_reg <= 8'd128;
            start_sector_reg <= '0;
            spt_reg          <= SPT_W'(63);
            heads_reg        <= HEAD_W'(255);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DISK_MAPPED: disk_mapped_reg  <= cfg_data[0];
                CFG_USE_LBA:     use_lba_reg      <= cfg_data[0];
                CFG_DRIVE:       drive_number_reg <= cfg_data[7:0];
                CFG_START:       start_sector_reg <= cfg_data[BLOCK_W-1:0];
                CFG_SPT:         spt_reg          <= cfg_data[SPT_W-1:0];
                CFG_HEADS:       heads_reg        <= cfg_data[HEAD_W-1:0];
                default:         ;
            endcase
        end
    end

    // Busy for the first cycle out of reset only.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
        end
    end

    assign busy = busy_reg;

    // Command decode. Unmapped and logical block commands take the short path.
    // The user must change configuration only while nothing is in flight; the block
    // does not enforce this. Then the two paths never deliver in the same cycle.
    always_comb
    begin
        accept     = start && !busy_reg;
        short_mode = !disk_mapped_reg || use_lba_reg;
        short_acc  = accept && short_mode;
        sec_ext    = BLOCK_W'(sector);
        too_large  = |sec_ext[BLOCK_W-1:CHS_W];
        buf_pass   = (func == FUNC_VERIFY) ? 32'd0 : buffer_address;
        spt_eff    = (spt_reg == '0) ? SPT_W'(1) : spt_reg;
        heads_eff  = (heads_reg == '0) ? HEAD_W'(1) : heads_reg;
    end

    // Entry stage: relative sector plus partition start, 32-bit wrap.
    always_comb
    begin
        s0_valid_next = accept && !short_mode;
        s0_rel_next   = sec_ext[CHS_W-1:0] + start_sector_reg[CHS_W-1:0];
        if (too_large)
        begin
            s0_side_next        = '0;
            s0_side_next.status = ST_BIG;
        end
        else
        begin
            s0_side_next.status  = ST_CHS;
            s0_side_next.command = func;
            s0_side_next.count   = sector_count;
            s0_side_next.buffer  = buf_pass;
            s0_side_next.sect    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= s0_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_rel_reg  <= s0_rel_next;
        s0_side_reg <= s0_side_next;
    end

    // First row: divide by sectors per track.
    dstc_chain #(
        .DIV_W (SPT_W)
    ) u_spt_chain (
        .clk         (clk),
        .rst_n       (rst_n),
        .divisor     (spt_eff),
        .in_valid    (s0_valid_reg),
        .in_dividend (s0_rel_reg),
        .in_side     (s0_side_reg),
        .out_valid   (c1_valid),
        .out_rem     (c1_rem),
        .out_quot    (c1_quot),
        .out_side    (c1_side)
    );

    // The sector number is the remainder plus one.
    always_comb
    begin
        mid_side      = c1_side;
        mid_side.sect = c1_rem + SPT_W'(1);
    end

    // Second row: divide the track number by heads.
    dstc_chain #(
        .DIV_W (HEAD_W)
    ) u_head_chain (
        .clk         (clk),
        .rst_n       (rst_n),
        .divisor     (heads_eff),
        .in_valid    (c1_valid),
        .in_dividend (c1_quot),
        .in_side     (mid_side),
        .out_valid   (c2_valid),
        .out_rem     (c2_rem),
        .out_quot    (c2_quot),
        .out_side    (c2_side)
    );

    // Result selection and packing of the BIOS words.
    always_comb
    begin
        done_next = short_acc || c2_valid;
        priority if (short_acc)
        begin
            cs_word_next = '0;
            hd_word_next = '0;
            if (!disk_mapped_reg)
            begin
                status_next  = ST_NOMAP;
                command_next = '0;
                block_next   = '0;
                count_next   = '0;
                buffer_next  = '0;
            end
            else
            begin
                status_next  = ST_LBA;
                command_next = func;
                block_next   = sec_ext + start_sector_reg;
                count_next   = sector_count;
                buffer_next  = buf_pass;
            end
        end
        else
        begin
            status_next  = c2_side.status;
            command_next = c2_side.command;
            block_next   = '0;
            count_next   = c2_side.count;
            buffer_next  = c2_side.buffer;
            if (c2_side.status == ST_CHS)
            begin
                cs_word_next = {c2_quot[7:0], 8'd0} | {c2_quot[17:8], 6'd0}
                             | {10'd0, c2_side.sect};
                hd_word_next = {c2_rem[7:0], drive_number_reg};
            end
            else
            begin
                cs_word_next = '0;
                hd_word_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        command_reg <= command_next;
        block_reg   <= block_next;
        cs_word_reg <= cs_word_next;
        hd_word_reg <= hd_word_next;
        count_reg   <= count_next;
        buffer_reg  <= buffer_next;
    end

    assign done            = done_reg;
    assign status          = status_reg;
    assign command         = command_reg;
    assign block_address   = block_reg;
    assign cyl_sector_word = cs_word_reg;
    assign head_drive_word = hd_word_reg;
    assign count_out       = count_reg;
    assign buffer_out      = buffer_reg;

    // A short-path command is answered in the very next cycle.
    a_short_latency: assert property (@(posedge clk) disable iff (!rst_n)
        short_acc |=> done)
        else $error("short-path command not answered in the next cycle");

    // The division rows never deliver while the short path is taking a beat.
    a_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
        c2_valid |-> !short_acc)
        else $error("division result collides with a short-path beat");

    // A cylinder request always carries a sector number of at least one and a zero block address.
    a_chs_sector: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_CHS) |-> (cyl_sector_word[5:0] != '0 && block_address == '0))
        else $error("malformed cylinder request");

    // Error results carry nothing but their status.
    a_error_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_NOMAP || status == ST_BIG)) |->
        (cyl_sector_word == '0 && head_drive_word == '0 && count_out == '0
         && buffer_out == '0 && block_address == '0))
        else $error("error result carries payload");

endmodule

@@ tb/sv/tb_disk_sector_to_chs_command_unit.sv @@
// Self-checking testbench for the disk sector to CHS command unit.
`timescale 1ns / 100ps

module tb_disk_sector_to_chs_command_unit;

    import dstc_pkg::*;

    // Command codes that the package does not name.
    localparam logic [1:0] FUNC_READ  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_SPARE = 2'd3;

    // Settling margin on top of the depth of the cylinder path.
    localparam int SETTLE_CYCLES = 70;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int RANDOM_PHASES = 16;
    localparam int PHASE_BEATS   = 78;

    // One drive request as it appears on the result ports.
    typedef struct packed {
        status_t     status;
        logic [1:0]  command;
        logic [63:0] block_address;
        logic [15:0] cyl_sector_word;
        logic [15:0] head_drive_word;
        logic [7:0]  count_out;
        logic [31:0] buffer_out;
    } drive_request_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [1:0]            func;
    logic [63:0]           sector;
    logic [7:0]            sector_count;
    logic [31:0]           buffer_address;
    logic                  done;
    logic [1:0]            status;
    logic [1:0]            command;
    logic [BLOCK_W-1:0]    block_address;
    logic [15:0]           cyl_sector_word;
    logic [15:0]           head_drive_word;
    logic [7:0]            count_out;
    logic [31:0]           buffer_out;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Local copy of the configuration registers, starting from reset values.
    logic        cfg_mapped = 1'b0;
    logic        cfg_lba    = 1'b0;
    logic [7:0]  cfg_drive  = 8'd128;
    logic [63:0] cfg_start  = 64'd0;
    logic [5:0]  cfg_spt    = 6'd63;
    logic [8:0]  cfg_heads  = 9'd255;

    drive_request_t pending_requests[$];
    int unsigned    mismatch_count = 0;
    int unsigned    cycle_count = 0;
    logic           steady = 1'b0;

    disk_sector_to_chs_command_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .func            (func),
        .sector          (sector),
        .sector_count    (sector_count),
        .buffer_address  (buffer_address),
        .done            (done),
        .status          (status),
        .command         (command),
        .block_address   (block_address),
        .cyl_sector_word (cyl_sector_word),
        .head_drive_word (head_drive_word),
        .count_out       (count_out),
        .buffer_out      (buffer_out),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Works out the request that one command produces under the current registers.
    function automatic drive_request_t predict_request(input logic [1:0] f,
                                                       input logic [63:0] sec,
                                                       input logic [7:0] cnt,
                                                       input logic [31:0] addr);
        drive_request_t req;
        logic [31:0] spt;
        logic [31:0] heads;
        logic [31:0] linear;
        logic [31:0] track;
        logic [31:0] sect;
        logic [31:0] head;
        logic [31:0] cyl;
        logic [63:0] cs_word;
        logic [31:0] hd_word;
        req = '0;
        if (!cfg_mapped)
        begin
            req.status = ST_NOMAP;
            return req;
        end
        if (cfg_lba)
        begin
            req.status        = ST_LBA;
            req.block_address = sec + cfg_start;
        end
        else
        begin
            if (sec[63:32] != 32'd0)
            begin
                req.status = ST_BIG;
                return req;
            end
            // A zero geometry register behaves as one.
            spt    = (cfg_spt == 6'd0) ? 32'd1 : {26'd0, cfg_spt};
            heads  = (cfg_heads == 9'd0) ? 32'd1 : {23'd0, cfg_heads};
            linear = sec[31:0] + cfg_start[31:0];
            sect   = linear % spt + 32'd1;
            track  = linear / spt;
            head   = track % heads;
            cyl    = track / heads;
            // Cylinder bits 8 and up land at bit 6; everything above bit 15 is lost.
            cs_word = {32'd0, sect} | ({56'd0, cyl[7:0]} << 8) | ({32'd0, cyl >> 8} << 6);
            hd_word = {24'd0, cfg_drive} | (head << 8);
            req.status          = ST_CHS;
            req.cyl_sector_word = cs_word[15:0];
            req.head_drive_word = hd_word[15:0];
        end
        req.command    = f;
        req.count_out  = cnt;
        req.buffer_out = (f == FUNC_VERIFY) ? 32'd0 : addr;
        return req;
    endfunction

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // Each request beat is checked against the oldest outstanding command.
    always @(posedge clk)
    begin : check_requests
        drive_request_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (pending_requests.size() == 0)
            begin
                $error("request beat with no command outstanding");
                mismatch_count++;
            end
            else
            begin
                want = pending_requests.pop_front();
                compare_field("status", want.status, status);
                compare_field("command", want.command, command);
                compare_field("block_address", want.block_address, block_address);
                compare_field("cyl_sector_word", want.cyl_sector_word, cyl_sector_word);
                compare_field("head_drive_word", want.head_drive_word, head_drive_word);
                compare_field("count_out", want.count_out, count_out);
                compare_field("buffer_out", want.buffer_out, buffer_out);
            end
        end
    end

    // Guard against a hang.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Sends one command beat. Outside a steady stretch each cycle is left idle
    // with a chance of about one in three before the beat goes out.
    // start is left high on return so that a following beat can go back to back.
    task automatic send_command(input logic [1:0] f, input logic [63:0] sec,
                                input logic [7:0] cnt, input logic [31:0] addr);
        while (!steady && $urandom_range(99) < 34)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start          <= 1'b1;
        func           <= f;
        sector         <= sec;
        sector_count   <= cnt;
        buffer_address <= addr;
        do
            @(posedge clk);
        while (busy);
        pending_requests.push_back(predict_request(f, sec, cnt, addr));
    endtask

    // Stops sending and waits until the block has delivered everything.
    task automatic wait_until_idle();
        start <= 1'b0;
        while (pending_requests.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes one register; the caller lowers the write enable afterwards.
    task automatic write_register(input cfg_index_t idx, input logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            CFG_DISK_MAPPED: cfg_mapped = value[0];
            CFG_USE_LBA:     cfg_lba    = value[0];
            CFG_DRIVE:       cfg_drive  = value[7:0];
            CFG_START:       cfg_start  = value;
            CFG_SPT:         cfg_spt    = value[5:0];
            CFG_HEADS:       cfg_heads  = value[8:0];
            default:         ;
        endcase
    endtask

    // Drains the block, then writes the whole register set.
    task automatic apply_setting(input logic mapped, input logic lba, input logic [7:0] drive,
                                 input logic [63:0] first, input logic [5:0] spt,
                                 input logic [8:0] heads);
        wait_until_idle();
        write_register(CFG_DISK_MAPPED, {63'd0, mapped});
        write_register(CFG_USE_LBA, {63'd0, lba});
        write_register(CFG_DRIVE, {56'd0, drive});
        write_register(CFG_START, first);
        write_register(CFG_SPT, {58'd0, spt});
        write_register(CFG_HEADS, {55'd0, heads});
        cfg_we <= 1'b0;
    endtask

    // Reset values: unmapped first, then cylinder mode on the default geometry.
    task automatic test_reset_values();
        send_command(FUNC_READ, 64'd5, 8'd1, 32'h0000_1000);
        send_command(FUNC_WRITE, '1, 8'hff, '1);
        wait_until_idle();
        write_register(CFG_DISK_MAPPED, 64'd1);
        cfg_we <= 1'b0;
        send_command(FUNC_READ, 64'd0, 8'd0, 32'd0);
        send_command(FUNC_WRITE, 64'd1_000_000, 8'd7, 32'hdead_beef);
    endtask

    // Logical block mode, including the 64-bit wrap and every command code.
    task automatic test_block_mode();
        apply_setting(1'b1, 1'b1, 8'h00, '1, 6'd63, 9'd255);
        send_command(FUNC_READ, 64'd0, 8'd0, 32'd0);
        send_command(FUNC_WRITE, '1, 8'hff, '1);
        send_command(FUNC_VERIFY, 64'd1, 8'h80, '1);
        send_command(FUNC_SPARE, 64'h8000_0000_0000_0000, 8'd1, 32'ha5a5_5a5a);
    endtask

    // Cylinder mode: edges of the 32-bit range and sectors that are too large.
    task automatic test_cylinder_mode();
        apply_setting(1'b1, 1'b0, 8'hff, 64'h1234_5678_ffff_ffff, 6'd63, 9'd255);
        send_command(FUNC_READ, 64'd0, 8'd3, 32'h8000_0000);
        send_command(FUNC_WRITE, 64'd1, 8'd255, 32'h0000_0001);
        send_command(FUNC_VERIFY, 64'h0000_0000_ffff_ffff, 8'd0, '1);
        send_command(FUNC_READ, 64'h0000_0001_0000_0000, 8'd9, 32'h1234_5678);
        send_command(FUNC_SPARE, '1, 8'd4, '1);
    endtask

    // Zero geometry acts as one, giving very large cylinder numbers.
    task automatic test_zero_geometry();
        apply_setting(1'b1, 1'b0, 8'h80, 64'd0, 6'd0, 9'd0);
        send_command(FUNC_READ, 64'h0000_0000_ffff_ffff, 8'd1, 32'd0);
        send_command(FUNC_WRITE, 64'h0001_2345, 8'd2, 32'h4000_0000);
    endtask

    // Head counts at and beyond the top of the range, and the smallest geometry.
    task automatic test_geometry_limits();
        apply_setting(1'b1, 1'b0, 8'h00, 64'd0, 6'd1, 9'd511);
        send_command(FUNC_READ, 64'h0000_0000_ffff_ffff, 8'd1, 32'd0);
        send_command(FUNC_WRITE, 64'd510, 8'd2, 32'd0);
        apply_setting(1'b1, 1'b0, 8'h81, 64'd0, 6'd63, 9'd256);
        send_command(FUNC_READ, 64'h00ff_fffe, 8'd1, 32'd0);
        apply_setting(1'b1, 1'b0, 8'h81, 64'hffff_ffff, 6'd1, 9'd1);
        send_command(FUNC_READ, 64'h0001_0401, 8'd1, 32'd0);
    endtask

    // Unmapping again hides everything, whatever the mode.
    task automatic test_unmapped();
        apply_setting(1'b0, 1'b1, 8'h12, '1, 6'd17, 9'd16);
        send_command(FUNC_SPARE, '1, 8'hff, '1);
    endtask

    function automatic logic [63:0] random_sector();
        if (cfg_mapped && !cfg_lba && $urandom_range(99) >= 15)
        begin
            case ($urandom_range(3))
                0:       return {32'd0, 32'hffff_ffff};
                1:       return {48'd0, 16'($urandom)};
                default: return {32'd0, 32'($urandom)};
            endcase
        end
        return {32'($urandom), 32'($urandom)};
    endfunction

    // Random phases, each under a fresh random register set.
    task automatic test_random_traffic();
        logic [63:0] first;
        logic [5:0]  spt;
        logic [8:0]  heads;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case ($urandom_range(3))
                0:       first = '0;
                1:       first = '1;
                2:       first = {32'd0, 32'($urandom)};
                default: first = {32'($urandom), 32'($urandom)};
            endcase
            case ($urandom_range(4))
                0:       spt = 6'd0;
                1:       spt = 6'd63;
                2:       spt = 6'd1;
                default: spt = 6'($urandom_range(63));
            endcase
            case ($urandom_range(5))
                0:       heads = 9'd0;
                1:       heads = 9'd256;
                2:       heads = 9'd511;
                3:       heads = 9'd1;
                default: heads = 9'($urandom_range(511));
            endcase
            apply_setting($urandom_range(9) != 0, 1'($urandom_range(1)),
                          8'($urandom_range(255)), first, spt, heads);
            // One phase runs with no gaps at all.
            steady = (phase == 5);
            for (int n = 0; n < PHASE_BEATS; n++)
                send_command(2'($urandom_range(3)), random_sector(),
                             8'($urandom_range(255)), 32'($urandom));
        end
        steady = 1'b0;
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        start          <= 1'b0;
        func           <= FUNC_READ;
        sector         <= '0;
        sector_count   <= '0;
        buffer_address <= '0;
        cfg_we         <= 1'b0;
        cfg_index      <= CFG_DISK_MAPPED;
        cfg_data       <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_block_mode();
        test_cylinder_mode();
        test_zero_geometry();
        test_geometry_limits();
        test_unmapped();
        test_random_traffic();
        wait_until_idle();

        if (mismatch_count == 0 && pending_requests.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
